[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Same, with the consequent checked in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/tma_pkg.sv]
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants for the trailing moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package tma_pkg;

    // width of the window_size register
    localparam int WIN_W = 7;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

`default_nettype wire

[src/tma_alu.sv]
// ----------------------------------------------------------------------------
// tma_alu
// Shared add/subtract unit used for accumulate, negate and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_alu #(
    parameter int W = 24
) (
    input  tma_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_sum
);
    import tma_pkg::*;

    logic [W-1:0] w_b;

    assign w_b   = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign o_sum = i_a + w_b + W'(i_op == ALU_SUB);

endmodule

`default_nettype wire

[src/tma_ring.sv]
// ----------------------------------------------------------------------------
// tma_ring
// Sample history: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[src/trailing_moving_average.sv]
// ----------------------------------------------------------------------------
// trailing_moving_average
// Streaming trailing mean of signed samples, one shared adder under a sequencer.
//   Input channel (i_valid / o_stall): i_sample, i_first_of_sequence. An item
//   is taken when i_valid is high and o_stall is low; o_stall stays high while
//   an item is being worked on.
//   Output channel (o_valid / i_stall): o_average from an output register, so a
//   new item may be taken while the last result still waits.
//   i_cfg_we / i_cfg_wdata write window_size (reset value 1); the user must
//   write it only while idle, the block does not enforce this. A zero window
//   takes items and drops them: no result, no change of state.
//   Steps: with n = min(fill, window), n history reads go through the one read
//   port and the shared adder, then one restoring divide step per sum bit on
//   that adder. o_valid rises as the sequencer returns to idle, where the next
//   item can be taken. If the previous result is still stalled when a new one
//   is ready, the sequencer waits in its last state and o_stall stays high.
//   Reset (sync, active low) clears pointer and fill count and sets the window
//   to 1; history is not cleared, only entries of the current sequence are read.
// ----------------------------------------------------------------------------
`default_nettype none

module trailing_moving_average #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config
    input  logic                           i_cfg_we,
    input  logic [tma_pkg::WIN_W-1:0]      i_cfg_wdata,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_first_of_sequence,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_average
);
    import tma_pkg::*;

`include "assert_macros.svh"

    // sizes
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
    localparam int ALU_W  = SUM_W + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int AD_W   = CNT_W + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;  // read history, accumulate
    localparam logic [2:0] ST_ABS  = 3'd2;  // sum to magnitude
    localparam logic [2:0] ST_DIV  = 3'd3;  // restoring divide, one bit/cycle
    localparam logic [2:0] ST_SGN  = 3'd4;  // restore sign of quotient
    localparam logic [2:0] ST_FIN  = 3'd5;  // load output register

    logic [2:0]        r_state;
    logic [WIN_W-1:0]  r_win;
    logic [PTR_W-1:0]  r_wp;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_iss;
    logic              r_iss_done;
    logic              r_rd_vld;
    logic [SUM_W-1:0]  r_acc;
    logic [CNT_W:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_neg;
    logic              r_ovld;
    logic [SAMPLE_WIDTH-1:0] r_avg;

    logic              w_accept;
    logic              w_take;
    logic [PTR_W-1:0]  n_wp;
    logic [CNT_W-1:0]  n_fill;
    logic [CMP_W-1:0]  w_win_sat;
    logic [CNT_W-1:0]  n_n;
    logic              w_issue;
    logic [AD_W-1:0]   w_wp_ext;
    logic [AD_W-1:0]   w_k_ext;
    logic [AD_W-1:0]   w_rd_addr_ext;
    logic [PTR_W-1:0]  w_rd_addr;
    logic [SAMPLE_WIDTH-1:0] w_rd_data;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_borrow;
    logic              w_out_free;

    t_alu_op           w_op;
    logic [ALU_W-1:0]  w_a;
    logic [ALU_W-1:0]  w_b;
    logic [ALU_W-1:0]  w_res;

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_ovld;
    assign o_average = r_avg;

    assign w_accept  = i_valid && (r_state == ST_IDLE);
    assign w_take    = w_accept && (r_win != '0);   // zero window drops it

    // ring pointer and fill count after this sample
    assign n_wp = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;

    always_comb begin
        if (i_first_of_sequence) begin
            n_fill = CNT_W'(1);
        end else if (r_fill < CNT_W'(MAX_WINDOW)) begin
            n_fill = r_fill + 1'b1;
        end else begin
            n_fill = r_fill;
        end
    end

    // samples to average: min(fill, saturated window)
    assign w_win_sat = (CMP_W'(r_win) > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW)
                                                            : CMP_W'(r_win);
    assign n_n = (CMP_W'(n_fill) < w_win_sat) ? n_fill : w_win_sat[CNT_W-1:0];

    // history read address: wp - k, modulo the ring depth
    assign w_issue  = (r_state == ST_SUM) && !r_iss_done;
    assign w_wp_ext = AD_W'(r_wp);
    assign w_k_ext  = AD_W'(r_iss);
    assign w_rd_addr_ext = (w_k_ext > w_wp_ext) ? w_wp_ext + AD_W'(MAX_WINDOW) - w_k_ext
                                                : w_wp_ext - w_k_ext;
    assign w_rd_addr = w_rd_addr_ext[PTR_W-1:0];

    tma_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_WIDTH),
        .AW    (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_take),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // operand select for the shared adder
    assign w_rem_sh = {r_rem[CNT_W-1:0], r_acc[SUM_W-1]};

    always_comb begin
        unique case (r_state) inside
            ST_SUM: begin
                w_op = ALU_ADD;
                w_a  = ALU_W'($signed(r_acc));
                w_b  = ALU_W'($signed(w_rd_data));
            end
            ST_DIV: begin
                w_op = ALU_SUB;
                w_a  = ALU_W'(w_rem_sh);
                w_b  = ALU_W'(r_n);
            end
            ST_ABS, ST_SGN: begin
                w_op = ALU_SUB;
                w_a  = '0;
                w_b  = ALU_W'($signed(r_acc));
            end
            default: begin
                w_op = ALU_ADD;
                w_a  = '0;
                w_b  = '0;
            end
        endcase
    end

    tma_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_sum (w_res)
    );

    assign w_borrow   = w_res[ALU_W-1];
    assign w_out_free = !r_ovld || !i_stall;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(1);
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wp       <= '0;
            r_fill     <= '0;
            r_iss_done <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            // output register: set when a result is loaded, cleared once taken
            if ((r_state == ST_FIN) && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            r_rd_vld <= w_issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_wp       <= n_wp;
                        r_fill     <= n_fill;
                        r_iss_done <= 1'b0;
                        r_state    <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (w_issue && (r_iss == r_n)) begin
                        r_iss_done <= 1'b1;
                    end
                    if (r_iss_done && !r_rd_vld) begin
                        r_state <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= ST_SGN;
                    end
                end
                ST_SGN: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    r_n   <= n_n;
                    r_iss <= CNT_W'(1);
                    r_acc <= '0;
                end
            end
            ST_SUM: begin
                if (w_issue && (r_iss != r_n)) begin
                    r_iss <= r_iss + 1'b1;
                end
                if (r_rd_vld) begin
                    r_acc <= w_res[SUM_W-1:0];
                end
            end
            ST_ABS: begin
                r_neg  <= r_acc[SUM_W-1];
                if (r_acc[SUM_W-1]) begin
                    r_acc <= w_res[SUM_W-1:0];
                end
                r_rem  <= '0;
                r_dcnt <= DCNT_W'(SUM_W);
            end
            ST_DIV: begin
                r_rem  <= w_borrow ? w_rem_sh : w_res[CNT_W:0];
                r_acc  <= {r_acc[SUM_W-2:0], !w_borrow};
                r_dcnt <= r_dcnt - 1'b1;
            end
            ST_SGN: begin
                if (r_neg) begin
                    r_acc <= w_res[SUM_W-1:0];
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    r_avg <= r_acc[SAMPLE_WIDTH-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // checks
    `ASSERT_IMPL(a_iss_range, r_state == ST_SUM, (r_iss <= r_n) && (r_n != '0), "bad read count")
    `ASSERT_IMPL(a_rem_range, r_state == ST_DIV, r_rem < {1'b0, r_n}, "remainder too large")
    `ASSERT_NEXT(a_take_seq, w_take, r_state == ST_SUM, "accepted item did not start summing")

endmodule

`default_nettype wire

[sim/tb_trailing_moving_average.sv]
// ----------------------------------------------------------------------------
// tb_trailing_moving_average
// Self-checking bench for the streaming trailing moving average.
// A behavioral ring-buffer model predicts one average per sample while the
// window is nonzero. Results are checked in order as they leave the output
// channel. Directed checks cover sample extremes, truncation
// toward zero, the zero window, window saturation and window changes within
// a sequence. Random sequences then run under four idling modes.
// ----------------------------------------------------------------------------
module tb_trailing_moving_average;

    localparam int MAX_WIN  = 64;
    localparam int SMP_W    = 16;
    localparam int SETTLE   = 120;   // longer than the worst item latency

    // idling modes of the random phases
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                        i_clk               = 1'b0;
    logic                        i_rst_n             = 1'b0;
    logic                        i_cfg_we            = 1'b0;
    logic [tma_pkg::WIN_W-1:0]   i_cfg_wdata         = '0;
    logic                        i_valid             = 1'b0;
    logic                        o_stall;
    logic signed [SMP_W-1:0]     i_sample            = '0;
    logic                        i_first_of_sequence = 1'b0;
    logic                        o_valid;
    logic                        i_stall             = 1'b0;
    logic signed [SMP_W-1:0]     o_average;

    trailing_moving_average #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SMP_W)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample            (i_sample),
        .i_first_of_sequence (i_first_of_sequence),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_average           (o_average)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the averager: sample ring, pointer, fill and window.
    // ------------------------------------------------------------------------
    logic signed [SMP_W-1:0]   sample_ring [MAX_WIN];
    logic [5:0]                ring_wr_ptr;
    int                        seq_fill;
    logic [tma_pkg::WIN_W-1:0] window_reg;

    logic signed [SMP_W-1:0]   expected_averages [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int items_dropped  = 0;
    int averages_seen  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // generous cap on the run time
    initial begin
        #10_000_000;
        $display("Timeout with %0d averages still pending", expected_averages.size());
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Mean of the last min(fill, window) samples, queued for the checker.
    // A zero window drops the item and leaves all state alone.
    task automatic predict_average(input logic signed [SMP_W-1:0] smp, input logic first);
        int win;
        int n;
        int acc;
        int quot;
        begin
            if (window_reg == 0) begin
                items_dropped++;
                return;
            end
            win = (window_reg > MAX_WIN) ? MAX_WIN : int'(window_reg);
            if (first)
                seq_fill = 0;
            sample_ring[ring_wr_ptr] = smp;
            ring_wr_ptr = ring_wr_ptr + 6'd1;
            if (seq_fill < MAX_WIN)
                seq_fill++;
            n = (seq_fill < win) ? seq_fill : win;
            acc = 0;
            for (int k = 1; k <= n; k++)
                acc += int'(sample_ring[(int'(ring_wr_ptr) + MAX_WIN - k) % MAX_WIN]);
            quot = acc / n;   // SV division truncates toward zero
            expected_averages = {expected_averages, quot[SMP_W-1:0]};
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted average against the oldest prediction.
    // Output ports are read before the edge's updates land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            averages_seen++;
            if (expected_averages.size() == 0) begin
                report_mismatch($sformatf("unexpected average %0d", o_average));
            end else begin
                if (o_average !== expected_averages[0])
                    report_mismatch($sformatf("average %0d, expected %0d",
                                              o_average, expected_averages[0]));
                void'(expected_averages.pop_front());
            end
        end
    end

    // Offer one item, with a random gap first; valid stays high on return
    // so that back-to-back items need no re-raise.
    task automatic send_item(input logic signed [SMP_W-1:0] smp, input logic first);
        begin
            if ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
            end
            i_valid             <= 1'b1;
            i_sample            <= smp;
            i_first_of_sequence <= first;
            do @(posedge i_clk); while (o_stall);
            items_sent++;
            predict_average(smp, first);
        end
    endtask

    task automatic drain_and_settle();
        begin
            i_valid <= 1'b0;
            while (expected_averages.size() != 0)
                @(posedge i_clk);
            // zero-window items leave no result to wait for
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    // window writes happen only once the block has gone quiet
    task automatic set_window(input int w);
        begin
            drain_and_settle();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= w[tma_pkg::WIN_W-1:0];
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            window_reg = w[tma_pkg::WIN_W-1:0];
        end
    endtask

    // extremes show up often so that saturation and sign handling get hit
    function automatic logic signed [SMP_W-1:0] pick_sample();
        logic [31:0] r;
        begin
            r = $urandom;
            case ($urandom_range(0, 9))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return -16'sd1;
                3:       return 16'sd0;
                default: return r[SMP_W-1:0];
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Reset window is 1: each average equals its own sample.
    task automatic test_reset_window();
        begin
            send_item(16'sh7FFF, 1'b1);
            send_item(16'sh8000, 1'b0);
            send_item(16'sd0,    1'b0);
            send_item(-16'sd1,   1'b0);
        end
    endtask

    // Odd sums over two samples: -3/2 must give -1, and the extremes must
    // not overflow.
    task automatic test_truncation();
        begin
            set_window(2);
            send_item(-16'sd3,   1'b1);
            send_item(16'sd0,    1'b0);
            send_item(16'sd3,    1'b0);
            send_item(16'sh7FFF, 1'b1);
            send_item(16'sh7FFF, 1'b0);
            send_item(16'sh8000, 1'b0);
        end
    endtask

    // Zero window drops items, start flag included; the next window then
    // averages over the sequence that was running before.
    task automatic test_zero_window();
        begin
            set_window(0);
            send_item(16'sd100, 1'b1);
            send_item(16'sd200, 1'b0);
            set_window(3);
            send_item(16'sd9,   1'b0);
        end
    endtask

    // Window above the ring size saturates; shrinking and growing the window
    // mid-sequence re-reads the ring.
    task automatic test_window_change();
        begin
            set_window(127);
            send_item(16'sd5,  1'b1);
            send_item(16'sd6,  1'b0);
            send_item(-16'sd7, 1'b0);
            set_window(2);
            send_item(16'sd8,  1'b0);
            set_window(64);
            send_item(16'sd1,  1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Random sequences: mostly short, some past the ring size so the fill
    // saturates and the pointer wraps; a few stray start flags as noise.
    // ------------------------------------------------------------------------
    task automatic run_phase(input int w, input t_idle_mode mode, input int n_items);
        int sent;
        int seq_len;
        int sel;
        logic first;
        begin
            set_window(w);
            send_idle_pct  = (mode == IDLE_SENDER)   ? 79 : (mode == IDLE_BOTH) ? 28 : 0;
            recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 28 : 0;
            sent = 0;
            while (sent < n_items) begin
                sel = $urandom_range(99);
                if (sel < 65)      seq_len = $urandom_range(1, 16);
                else if (sel < 88) seq_len = $urandom_range(17, 63);
                else               seq_len = $urandom_range(64, 150);
                for (int k = 0; k < seq_len && sent < n_items; k++) begin
                    // a phase may carry on the previous sequence
                    if (k == 0)
                        first = (sent != 0) || ($urandom_range(3) != 0);
                    else
                        first = ($urandom_range(99) < 3);
                    send_item(pick_sample(), first);
                    sent++;
                end
            end
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic test_random_stream();
        begin
            run_phase(64,                     IDLE_NONE,     120);
            run_phase(1,                      IDLE_SENDER,   110);
            run_phase(127,                    IDLE_RECEIVER, 120);
            run_phase(0,                      IDLE_BOTH,      20);
            run_phase($urandom_range(2, 63),  IDLE_BOTH,     120);
            run_phase(65,                     IDLE_NONE,     120);
            run_phase($urandom_range(1, 127), IDLE_SENDER,   120);
            run_phase($urandom_range(2, 63),  IDLE_RECEIVER, 120);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        ring_wr_ptr = '0;
        seq_fill    = 0;
        window_reg  = 7'd1;
        for (int i = 0; i < MAX_WIN; i++)
            sample_ring[i] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_truncation();
        test_zero_window();
        test_window_change();
        test_random_stream();

        drain_and_settle();

        $display("Sent %0d samples (%0d dropped at window zero), checked %0d averages",
                 items_sent, items_dropped, averages_seen);
        $display("Windows 0 to 127 incl. saturation, four idling modes, ring wrap");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/tma_pkg.sv
src/tma_alu.sv
src/tma_ring.sv
src/trailing_moving_average.sv
sim/tb_trailing_moving_average.sv
